### rtl/core/cdq_pkg.sv
package cdq_pkg;

    localparam int DEPTH    = 128;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 8;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_SHIFT_IN,
        CMD_SHIFT_OUT,
        CMD_APPEND
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t                 cmd;
        logic signed [DATA_W-1:0] value;
        logic [CNT_W-1:0]         held;
    } chain_ctrl_t;

endpackage

### rtl/core/cdq_cell.sv
module cdq_cell
    import cdq_pkg::*;
(
    input  logic                     aclk,
    input  chain_ctrl_t              ctrl,
    input  logic [IDX_W-1:0]         idx,
    input  logic signed [DATA_W-1:0] left_q,
    input  logic signed [DATA_W-1:0] right_q,
    output logic signed [DATA_W-1:0] q,
    output logic signed [DATA_W-1:0] q_next
);

    logic signed [DATA_W-1:0] data_reg;

    always_comb begin
        case (ctrl.cmd)
            CMD_HOLD:      q_next = data_reg;
            CMD_SHIFT_IN:  q_next = left_q;
            CMD_SHIFT_OUT: q_next = right_q;
            CMD_APPEND:    q_next = (CNT_W'(idx) == ctrl.held) ? ctrl.value : data_reg;
            default:       q_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= q_next;
    end

    assign q = data_reg;

endmodule

### rtl/core/cdq_chain.sv
module cdq_chain
    import cdq_pkg::*;
(
    input  logic                     aclk,
    input  chain_ctrl_t              ctrl,
    output logic signed [DATA_W-1:0] head_q,
    output logic signed [DATA_W-1:0] head_next
);

    logic signed [DATA_W-1:0] q    [DEPTH];
    logic signed [DATA_W-1:0] qn   [DEPTH];
    logic signed [DATA_W-1:0] left [DEPTH];
    logic signed [DATA_W-1:0] right[DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign left[i] = ctrl.value;
        end else begin : g_inner_left
            assign left[i] = q[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right[i] = '0;
        end else begin : g_inner_right
            assign right[i] = q[i+1];
        end

        cdq_cell u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .idx     (IDX_W'(i)),
            .left_q  (left[i]),
            .right_q (right[i]),
            .q       (q[i]),
            .q_next  (qn[i])
        );
    end

    assign head_q    = q[0];
    assign head_next = qn[0];

endmodule

### rtl/core/circular_deque_core.sv
// A result is registered and appears on the m_ side in the cycle after its request is accepted.
// Throughput: one request per cycle; s_ready drops only while a result waits on m_ready.
// Two rows of cells hold the deque, one ordered from the front and one from the rear.
// A push shifts into cell zero of one row and lands at the fill position of the other.
// A pop shifts one row down by a cell and leaves the other row in place.
// Reset: aresetn is synchronous and active low; it empties the deque and clears m_valid.
module circular_deque_core
    import cdq_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [OP_W-1:0]            s_op,
    input  logic signed [DATA_W-1:0]   s_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic signed [DATA_W-1:0]   m_popped_value,
    output logic signed [DATA_W-1:0]   m_front_value,
    output logic signed [DATA_W-1:0]   m_rear_value,
    output logic                       m_is_empty,
    output logic                       m_is_full,
    output logic [OCC_W-1:0]           m_occupancy
);

    logic                     m_valid_reg;
    logic [CNT_W-1:0]         held_reg;
    logic [CNT_W-1:0]         held_next;
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;
    logic signed [DATA_W-1:0] popped_reg;
    logic signed [DATA_W-1:0] popped_next;
    logic signed [DATA_W-1:0] front_reg;
    logic signed [DATA_W-1:0] rear_reg;
    logic                     empty_reg;
    logic                     full_reg;
    logic [OCC_W-1:0]         occ_reg;

    chain_ctrl_t              ctrl_front;
    chain_ctrl_t              ctrl_rear;
    logic signed [DATA_W-1:0] front_head_q;
    logic signed [DATA_W-1:0] front_head_next;
    logic signed [DATA_W-1:0] rear_head_q;
    logic signed [DATA_W-1:0] rear_head_next;

    logic accept;
    logic is_full_now;
    logic is_empty_now;

    assign s_ready      = !m_valid_reg || m_ready;
    assign accept       = s_valid && s_ready;
    assign is_full_now  = (held_reg == CNT_W'(DEPTH));
    assign is_empty_now = (held_reg == '0);

    always_comb begin
        ctrl_front.cmd   = CMD_HOLD;
        ctrl_front.value = s_value;
        ctrl_front.held  = held_reg;
        ctrl_rear.cmd    = CMD_HOLD;
        ctrl_rear.value  = s_value;
        ctrl_rear.held   = held_reg;
        status_next      = STATUS_DONE;
        popped_next      = '0;
        held_next        = held_reg;
        if (accept) begin
            case (s_op)
                OP_PUSH_FRONT: begin
                    if (is_full_now) begin
                        status_next = STATUS_FULL;
                    end else begin
                        ctrl_front.cmd = CMD_SHIFT_IN;
                        ctrl_rear.cmd  = CMD_APPEND;
                        held_next      = held_reg + CNT_W'(1);
                    end
                end
                OP_PUSH_REAR: begin
                    if (is_full_now) begin
                        status_next = STATUS_FULL;
                    end else begin
                        ctrl_front.cmd = CMD_APPEND;
                        ctrl_rear.cmd  = CMD_SHIFT_IN;
                        held_next      = held_reg + CNT_W'(1);
                    end
                end
                OP_POP_FRONT: begin
                    if (is_empty_now) begin
                        status_next = STATUS_EMPTY;
                    end else begin
                        popped_next    = front_head_q;
                        ctrl_front.cmd = CMD_SHIFT_OUT;
                        held_next      = held_reg - CNT_W'(1);
                    end
                end
                OP_POP_REAR: begin
                    if (is_empty_now) begin
                        status_next = STATUS_EMPTY;
                    end else begin
                        popped_next   = rear_head_q;
                        ctrl_rear.cmd = CMD_SHIFT_OUT;
                        held_next     = held_reg - CNT_W'(1);
                    end
                end
                OP_QUERY: begin
                    status_next = STATUS_DONE;
                end
                default: begin
                    status_next = STATUS_DONE;
                end
            endcase
        end
    end

    cdq_chain u_front_chain (
        .aclk      (aclk),
        .ctrl      (ctrl_front),
        .head_q    (front_head_q),
        .head_next (front_head_next)
    );

    cdq_chain u_rear_chain (
        .aclk      (aclk),
        .ctrl      (ctrl_rear),
        .head_q    (rear_head_q),
        .head_next (rear_head_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            held_reg    <= '0;
        end else begin
            held_reg <= held_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            popped_reg <= popped_next;
            front_reg  <= (held_next == '0) ? EMPTY_VALUE : front_head_next;
            rear_reg   <= (held_next == '0) ? EMPTY_VALUE : rear_head_next;
            empty_reg  <= (held_next == '0);
            full_reg   <= (held_next == CNT_W'(DEPTH));
            occ_reg    <= OCC_W'(held_next);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_popped_value = popped_reg;
    assign m_front_value  = front_reg;
    assign m_rear_value   = rear_reg;
    assign m_is_empty     = empty_reg;
    assign m_is_full      = full_reg;
    assign m_occupancy    = occ_reg;

endmodule

### test/tb_circular_deque_core.sv
module tb_circular_deque_core;
    import cdq_pkg::*;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        int                       gap_after;
        bit                       wait_idle;
    } deque_req_t;

    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] popped;
        logic signed [DATA_W-1:0] front;
        logic signed [DATA_W-1:0] rear;
        logic                     empty;
        logic                     full;
        logic [OCC_W-1:0]         occ;
    } deque_res_t;

    logic                     aclk;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [OP_W-1:0]          s_op = '0;
    logic signed [DATA_W-1:0] s_value = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [STATUS_W-1:0]      m_status;
    logic signed [DATA_W-1:0] m_popped_value;
    logic signed [DATA_W-1:0] m_front_value;
    logic signed [DATA_W-1:0] m_rear_value;
    logic                     m_is_empty;
    logic                     m_is_full;
    logic [OCC_W-1:0]         m_occupancy;

    circular_deque_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_popped_value (m_popped_value),
        .m_front_value  (m_front_value),
        .m_rear_value   (m_rear_value),
        .m_is_empty     (m_is_empty),
        .m_is_full      (m_is_full),
        .m_occupancy    (m_occupancy)
    );

    deque_req_t deque_ops[$];
    deque_res_t owed_results[$];

    logic signed [DATA_W-1:0] mirror[DEPTH];
    int front_idx = 0;
    int rear_idx = 0;
    int mirror_held = 0;

    int  gen_held = 0;
    int  sender_calm = 0;
    int  total_items = 0;
    int  accepted_count = 0;
    int  err_count = 0;
    bit  stim_done = 1'b0;
    logic s_fire = 1'b0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  run_left = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1500000;
        $display("tb_circular_deque_core: errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            return 32'sh8000_0000;
        end else if (r < 6) begin
            return 32'sh7fff_ffff;
        end else if (r < 8) begin
            return 32'sd0;
        end else if (r < 10) begin
            return -32'sd1;
        end
        return $urandom;
    endfunction

    function automatic deque_res_t deque_apply(logic [OP_W-1:0] op,
                                               logic signed [DATA_W-1:0] value);
        deque_res_t r;
        r.status = STATUS_DONE;
        r.popped = '0;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
            if (mirror_held >= DEPTH) begin
                r.status = STATUS_FULL;
            end else begin
                if (mirror_held == 0) begin
                    front_idx = 0;
                    rear_idx = 0;
                    mirror[0] = value;
                end else if (op == OP_PUSH_FRONT) begin
                    front_idx = (front_idx + DEPTH - 1) % DEPTH;
                    mirror[front_idx] = value;
                end else begin
                    rear_idx = (rear_idx + 1) % DEPTH;
                    mirror[rear_idx] = value;
                end
                mirror_held++;
            end
        end else if (op == OP_POP_FRONT || op == OP_POP_REAR) begin
            if (mirror_held == 0) begin
                r.status = STATUS_EMPTY;
            end else begin
                r.popped = (op == OP_POP_FRONT) ? mirror[front_idx] : mirror[rear_idx];
                if (mirror_held == 1) begin
                    front_idx = 0;
                    rear_idx = 0;
                end else if (op == OP_POP_FRONT) begin
                    front_idx = (front_idx + 1) % DEPTH;
                end else begin
                    rear_idx = (rear_idx + DEPTH - 1) % DEPTH;
                end
                mirror_held--;
            end
        end
        r.front = (mirror_held == 0) ? EMPTY_VALUE : mirror[front_idx];
        r.rear  = (mirror_held == 0) ? EMPTY_VALUE : mirror[rear_idx];
        r.empty = (mirror_held == 0);
        r.full  = (mirror_held >= DEPTH);
        r.occ   = OCC_W'(mirror_held);
        return r;
    endfunction

    task automatic queue_op(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value,
                            input bit wait_idle);
        deque_req_t req;
        req.op = op;
        req.value = value;
        req.wait_idle = wait_idle;
        if (sender_calm > 0) begin
            sender_calm--;
            req.gap_after = 0;
        end else if ($urandom_range(0, 39) == 0) begin
            sender_calm = $urandom_range(20, 100);
            req.gap_after = 0;
        end else begin
            req.gap_after = pick_gap();
        end
        if ((op == OP_PUSH_FRONT || op == OP_PUSH_REAR) && gen_held < DEPTH) begin
            gen_held++;
        end else if ((op == OP_POP_FRONT || op == OP_POP_REAR) && gen_held > 0) begin
            gen_held--;
        end
        deque_ops.push_back(req);
        total_items++;
    endtask

    function automatic logic [OP_W-1:0] pick_push();
        return ($urandom_range(0, 1) != 0) ? OP_PUSH_REAR : OP_PUSH_FRONT;
    endfunction

    function automatic logic [OP_W-1:0] pick_pop();
        return ($urandom_range(0, 1) != 0) ? OP_POP_REAR : OP_POP_FRONT;
    endfunction

    initial begin
        int n;
        queue_op(OP_QUERY, 32'sd5, 1'b0);
        queue_op(OP_POP_FRONT, 32'sd0, 1'b0);
        queue_op(OP_POP_REAR, -32'sd1, 1'b0);
        queue_op(3'd5, 32'sd1, 1'b0);
        queue_op(3'd6, 32'sd2, 1'b0);
        queue_op(3'd7, 32'sd3, 1'b0);
        queue_op(OP_PUSH_FRONT, 32'sh8000_0000, 1'b0);
        queue_op(OP_POP_REAR, 32'sd0, 1'b0);
        queue_op(OP_PUSH_REAR, 32'sh7fff_ffff, 1'b0);
        queue_op(OP_PUSH_FRONT, -32'sd1, 1'b0);
        queue_op(OP_PUSH_FRONT, 32'sd0, 1'b0);
        queue_op(OP_PUSH_REAR, 32'sh5555_5555, 1'b0);
        queue_op(OP_PUSH_REAR, 32'shaaaa_aaaa, 1'b0);
        queue_op(3'd7, 32'sd0, 1'b0);
        queue_op(OP_POP_FRONT, 32'sd0, 1'b0);
        queue_op(OP_POP_REAR, 32'sd0, 1'b0);
        queue_op(OP_POP_FRONT, 32'sd0, 1'b0);
        queue_op(OP_POP_REAR, 32'sd0, 1'b0);
        queue_op(OP_POP_FRONT, 32'sd0, 1'b0);
        queue_op(OP_POP_REAR, 32'sd0, 1'b0);
        queue_op(OP_PUSH_REAR, 32'sd1, 1'b0);
        queue_op(OP_POP_FRONT, 32'sd0, 1'b0);

        queue_op(OP_QUERY, pick_value(), 1'b1);
        while (total_items < 1000) begin
            case ($urandom_range(0, 3))
                0: begin
                    while (gen_held < DEPTH) begin
                        if ($urandom_range(0, 9) == 0) begin
                            queue_op(OP_W'($urandom_range(2, 7)), pick_value(), 1'b0);
                        end else begin
                            queue_op(pick_push(), pick_value(), 1'b0);
                        end
                    end
                    n = $urandom_range(2, 5);
                    repeat (n) queue_op(pick_push(), pick_value(), 1'b0);
                end
                1: begin
                    while (gen_held > 0) begin
                        if ($urandom_range(0, 9) == 0) begin
                            queue_op(OP_W'($urandom_range(0, 7)), pick_value(), 1'b0);
                        end else begin
                            queue_op(pick_pop(), pick_value(), 1'b0);
                        end
                    end
                    n = $urandom_range(2, 5);
                    repeat (n) queue_op(pick_pop(), pick_value(), 1'b0);
                end
                2: begin
                    n = $urandom_range(20, 60);
                    repeat (n) begin
                        queue_op(OP_W'($urandom_range(0, 7)), pick_value(),
                                 $urandom_range(0, 99) == 0);
                    end
                end
                default: begin
                    n = $urandom_range(40, 100);
                    repeat (n) begin
                        if ($urandom_range(0, 1) != 0) begin
                            queue_op(pick_push(), pick_value(), 1'b0);
                        end else begin
                            queue_op(pick_pop(), pick_value(), 1'b0);
                        end
                    end
                end
            endcase
        end
        stim_done = 1'b1;
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    always @(negedge aclk) begin
        deque_req_t nxt;
        logic       next_valid;
        next_valid = s_valid && !s_fire;
        if (aresetn && stim_done && (!s_valid || s_fire)) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (deque_ops.size() > 0 &&
                         !(deque_ops[0].wait_idle && owed_results.size() != 0)) begin
                nxt = deque_ops.pop_front();
                next_valid = 1'b1;
                gap_left = nxt.gap_after;
                s_op <= nxt.op;
                s_value <= nxt.value;
            end
        end
        s_valid <= next_valid;
    end

    always @(negedge aclk) begin
        logic rdy;
        if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
            if (run_left > 0) begin
                run_left--;
            end else begin
                run_left = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200)
                                                        : $urandom_range(0, 8);
                stall_left = pick_gap();
            end
        end
        m_ready <= rdy;
    end

    always @(posedge aclk) begin
        deque_res_t want;
        s_fire <= s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                owed_results.push_back(deque_apply(s_op, s_value));
                accepted_count++;
            end
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: result with none expected, status %0d occupancy %0d",
                             $time, m_status, m_occupancy);
                    err_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (m_status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, m_status);
                        err_count++;
                    end
                    if (m_popped_value !== want.popped) begin
                        $display("%0t: popped_value expected %0d got %0d",
                                 $time, want.popped, m_popped_value);
                        err_count++;
                    end
                    if (m_front_value !== want.front) begin
                        $display("%0t: front_value expected %0d got %0d",
                                 $time, want.front, m_front_value);
                        err_count++;
                    end
                    if (m_rear_value !== want.rear) begin
                        $display("%0t: rear_value expected %0d got %0d",
                                 $time, want.rear, m_rear_value);
                        err_count++;
                    end
                    if (m_is_empty !== want.empty) begin
                        $display("%0t: is_empty expected %0d got %0d",
                                 $time, want.empty, m_is_empty);
                        err_count++;
                    end
                    if (m_is_full !== want.full) begin
                        $display("%0t: is_full expected %0d got %0d",
                                 $time, want.full, m_is_full);
                        err_count++;
                    end
                    if (m_occupancy !== want.occ) begin
                        $display("%0t: occupancy expected %0d got %0d",
                                 $time, want.occ, m_occupancy);
                        err_count++;
                    end
                end
            end
        end
    end

    initial begin
        @(posedge aresetn);
        @(negedge aclk);
        while (!stim_done || accepted_count != total_items || owed_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (8) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb_circular_deque_core: clean");
        end else begin
            $display("tb_circular_deque_core: errors");
        end
        $finish;
    end

endmodule
